[rtl/lbfm_pkg.sv]
// shared types and constants for the laser beam footprint mask
package lbfm_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int ZW           = 32;
  localparam int GAIN_W       = 31;
  localparam int ROUND_SHIFT  = 34;
  localparam int MASK_BACKOFF = 10;
  localparam int ADDR_W       = 5;
  localparam int REG_IDX_W    = 3;

  localparam logic [GAIN_W-1:0] INV_GAIN = 31'd652032874;

  localparam logic [REG_IDX_W-1:0] REG_MIN_RANGE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MOUNT_ANGLE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FOOTPRINT   = 3'd5;

  typedef logic signed [ZW-1:0] atan_t;

  localparam atan_t ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85005268,
    32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef struct packed {
    logic valid;
    logic bypass;
  } ctrl_t;

endpackage

[rtl/lbfm_cordic_stage.sv]
// one registered cordic rotation step
module lbfm_cordic_stage #(
  parameter int RANGE_BITS = 16,
  parameter int XW         = 27,
  parameter int SHIFT      = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  lbfm_pkg::ctrl_t               ctrl_i,
  input  logic [RANGE_BITS-1:0]         r_i,
  input  logic signed [XW-1:0]          x_i,
  input  logic signed [XW-1:0]          y_i,
  input  logic signed [lbfm_pkg::ZW-1:0] z_i,
  output lbfm_pkg::ctrl_t               ctrl_o,
  output logic [RANGE_BITS-1:0]         r_o,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o,
  output logic signed [lbfm_pkg::ZW-1:0] z_o
);

  localparam lbfm_pkg::atan_t ATAN = lbfm_pkg::ATAN_TAB[SHIFT];

  lbfm_pkg::ctrl_t               ctrl_r;
  logic [RANGE_BITS-1:0]         r_r;
  logic signed [XW-1:0]          x_r, y_r;
  logic signed [lbfm_pkg::ZW-1:0] z_r;
  logic signed [XW-1:0]          dx, dy;

  assign dx = y_i >>> SHIFT;
  assign dy = x_i >>> SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_i;
      if (!z_i[lbfm_pkg::ZW-1]) begin
        x_r <= x_i - dx;
        y_r <= y_i + dy;
        z_r <= z_i - ATAN;
      end else begin
        x_r <= x_i + dx;
        y_r <= y_i - dy;
        z_r <= z_i + ATAN;
      end
    end
  end

  assign ctrl_o = ctrl_r;
  assign r_o    = r_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule

[rtl/lbfm_geom.sv]
// gain scaling, offset, squared distance, footprint compare and range select
module lbfm_geom #(
  parameter int RANGE_BITS = 16,
  parameter int XW         = 27
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  lbfm_pkg::ctrl_t              ctrl_i,
  input  logic [RANGE_BITS-1:0]        r_i,
  input  logic signed [XW-1:0]         x_i,
  input  logic signed [XW-1:0]         y_i,
  input  logic [RANGE_BITS-1:0]        min_range,
  input  logic signed [RANGE_BITS-1:0] offset_x,
  input  logic signed [RANGE_BITS-1:0] offset_y,
  input  logic [RANGE_BITS-1:0]        footprint_radius,
  output logic                         valid_o,
  output logic [RANGE_BITS:0]          range_o,
  output logic                         masked_o
);

  localparam int PRW = XW + lbfm_pkg::GAIN_W;
  localparam int PW  = RANGE_BITS + 6;
  localparam int SW  = 2 * PW;
  localparam int OW  = RANGE_BITS + 4;
  localparam int QW  = 2 * OW;

  localparam logic signed [lbfm_pkg::GAIN_W-1:0] GAIN_S = signed'(lbfm_pkg::INV_GAIN);
  localparam logic signed [PRW-1:0] ROUND_C = PRW'(1) <<< (lbfm_pkg::ROUND_SHIFT - 1);
  localparam logic [RANGE_BITS:0]   BACKOFF = (RANGE_BITS + 1)'(lbfm_pkg::MASK_BACKOFF);

  lbfm_pkg::ctrl_t c1_r, c2_r, c3_r;
  logic [RANGE_BITS-1:0] r1_r, r2_r, r3_r;

  // stage 1: gain multiply
  logic signed [PRW-1:0] prodx_nxt, prody_nxt, prodx_r, prody_r;
  assign prodx_nxt = PRW'(x_i) * PRW'(GAIN_S);
  assign prody_nxt = PRW'(y_i) * PRW'(GAIN_S);

  // stage 2: round to q4 and add offset
  logic signed [PRW-1:0] sumx, sumy, qx, qy;
  logic signed [OW-1:0]  offx16, offy16;
  logic signed [PW-1:0]  px_nxt, py_nxt, px_r, py_r;
  assign sumx   = prodx_r + ROUND_C;
  assign sumy   = prody_r + ROUND_C;
  assign qx     = sumx >>> lbfm_pkg::ROUND_SHIFT;
  assign qy     = sumy >>> lbfm_pkg::ROUND_SHIFT;
  assign offx16 = signed'({offset_x, 4'b0000});
  assign offy16 = signed'({offset_y, 4'b0000});
  assign px_nxt = PW'(qx) + PW'(offx16);
  assign py_nxt = PW'(qy) + PW'(offy16);

  // stage 3: squares
  logic signed [SW-1:0] sqx_nxt, sqy_nxt;
  logic [SW-1:0]        sqx_r, sqy_r;
  logic [OW-1:0]        rq;
  logic [QW-1:0]        rsq_nxt, rsq_r;
  assign sqx_nxt = px_r * px_r;
  assign sqy_nxt = py_r * py_r;
  assign rq      = {footprint_radius, 4'b0000};
  assign rsq_nxt = QW'(rq) * QW'(rq);

  // stage 4: compare and select
  logic [SW:0]         d2;
  logic                hit;
  logic                masked_r;
  logic [RANGE_BITS:0] range_r;
  logic                valid_r;
  assign d2  = (SW + 1)'(sqx_r) + (SW + 1)'(sqy_r);
  assign hit = !c3_r.bypass && (d2 < (SW + 1)'(rsq_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      c1_r    <= ctrl_i;
      c2_r    <= c1_r;
      c3_r    <= c2_r;
      valid_r <= c3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r    <= r_i;
      prodx_r <= prodx_nxt;
      prody_r <= prody_nxt;
      r2_r    <= r1_r;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      r3_r    <= r2_r;
      sqx_r   <= SW'(sqx_nxt);
      sqy_r   <= SW'(sqy_nxt);
      rsq_r   <= rsq_nxt;
      masked_r <= hit;
      range_r  <= hit ? ({1'b0, min_range} - BACKOFF) : {1'b0, r3_r};
    end
  end

  assign valid_o  = valid_r;
  assign range_o  = range_r;
  assign masked_o = masked_r;

endmodule

[rtl/laser_beam_footprint_mask.sv]
// top level of the laser beam footprint mask pipeline
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_stall     in_range_in, in_beam_angle, in_not_finite
//  out      output     out_valid / out_stall   out_range_out, out_masked
//  cfg      input      psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// one beam per cycle while in_stall is low; stages in order: range check, quadrant preset,
// 24 cordic stages, gain multiply, offset, square, compare, output register.
// reset clears all valid bits and loads the register reset values.
// a skid register behind the output takes one result while out_stall holds;
// in_stall rises only when that skid register is full, and the whole pipe freezes.
module laser_beam_footprint_mask #(
  parameter int RANGE_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [RANGE_BITS-1:0]             in_range_in,
  input  logic [ANGLE_BITS-1:0]             in_beam_angle,
  input  logic                              in_not_finite,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [RANGE_BITS:0]        out_range_out,
  output logic                              out_masked,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lbfm_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int XW = RANGE_BITS + 11;
  localparam int ZW = lbfm_pkg::ZW;
  localparam int NS = lbfm_pkg::CORDIC_STEPS;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // configuration registers
  logic [RANGE_BITS-1:0]        min_range_r, max_range_r, footprint_r;
  logic signed [RANGE_BITS-1:0] offset_x_r, offset_y_r;
  logic [ANGLE_BITS-1:0]        mount_angle_r;
  logic [lbfm_pkg::REG_IDX_W-1:0] reg_idx;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lbfm_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r   <= '0;
      max_range_r   <= '1;
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      mount_angle_r <= '0;
      footprint_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        lbfm_pkg::REG_MIN_RANGE:   min_range_r   <= pwdata[RANGE_BITS-1:0];
        lbfm_pkg::REG_MAX_RANGE:   max_range_r   <= pwdata[RANGE_BITS-1:0];
        lbfm_pkg::REG_OFFSET_X:    offset_x_r    <= signed'(pwdata[RANGE_BITS-1:0]);
        lbfm_pkg::REG_OFFSET_Y:    offset_y_r    <= signed'(pwdata[RANGE_BITS-1:0]);
        lbfm_pkg::REG_MOUNT_ANGLE: mount_angle_r <= pwdata[ANGLE_BITS-1:0];
        lbfm_pkg::REG_FOOTPRINT:   footprint_r   <= pwdata[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lbfm_pkg::REG_MIN_RANGE:   prdata = 32'(min_range_r);
      lbfm_pkg::REG_MAX_RANGE:   prdata = 32'(max_range_r);
      lbfm_pkg::REG_OFFSET_X:    prdata = 32'(offset_x_r);
      lbfm_pkg::REG_OFFSET_Y:    prdata = 32'(offset_y_r);
      lbfm_pkg::REG_MOUNT_ANGLE: prdata = 32'(mount_angle_r);
      lbfm_pkg::REG_FOOTPRINT:   prdata = 32'(footprint_r);
      default:                   prdata = '0;
    endcase
  end

  // pipeline enable and output skid
  logic skid_v_r;
  logic en;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage 0: range check and phase sum
  lbfm_pkg::ctrl_t       c0_r;
  logic [RANGE_BITS-1:0] r0_r;
  logic [ANGLE_BITS-1:0] phase0_r;
  logic                  bypass0;
  assign bypass0 = in_not_finite || (in_range_in > max_range_r) ||
                   (in_range_in < min_range_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
    end else if (en) begin
      c0_r.valid  <= in_valid;
      c0_r.bypass <= bypass0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r     <= in_range_in;
      phase0_r <= in_beam_angle + mount_angle_r;
    end
  end

  // stage 1: quadrant preset
  logic [31:0]           phase32;
  logic signed [XW-1:0]  s0;
  logic signed [XW-1:0]  xq, yq;
  lbfm_pkg::ctrl_t       pre_c_r;
  logic [RANGE_BITS-1:0] pre_r_r;
  logic signed [XW-1:0]  pre_x_r, pre_y_r;
  logic signed [ZW-1:0]  pre_z_r;
  lbfm_pkg::ctrl_t       c_s [NS+1];
  logic [RANGE_BITS-1:0] r_s [NS+1];
  logic signed [XW-1:0]  x_s [NS+1];
  logic signed [XW-1:0]  y_s [NS+1];
  logic signed [ZW-1:0]  z_s [NS+1];

  assign phase32 = {phase0_r, {(32 - ANGLE_BITS){1'b0}}};
  assign s0      = signed'(XW'({r0_r, 8'b0}));

  always_comb begin
    case (phase32[31:30])
      QUAD_0: begin xq = s0;  yq = '0;  end
      QUAD_1: begin xq = '0;  yq = s0;  end
      QUAD_2: begin xq = -s0; yq = '0;  end
      QUAD_3: begin xq = '0;  yq = -s0; end
      default: begin xq = '0; yq = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_c_r <= '0;
    end else if (en) begin
      pre_c_r <= c0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r_r <= r0_r;
      pre_x_r <= xq;
      pre_y_r <= yq;
      pre_z_r <= signed'({2'b00, phase32[29:0]});
    end
  end

  assign c_s[0] = pre_c_r;
  assign r_s[0] = pre_r_r;
  assign x_s[0] = pre_x_r;
  assign y_s[0] = pre_y_r;
  assign z_s[0] = pre_z_r;

  // cordic stages
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    lbfm_cordic_stage #(
      .RANGE_BITS(RANGE_BITS),
      .XW        (XW),
      .SHIFT     (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctrl_i(c_s[i]),
      .r_i   (r_s[i]),
      .x_i   (x_s[i]),
      .y_i   (y_s[i]),
      .z_i   (z_s[i]),
      .ctrl_o(c_s[i+1]),
      .r_o   (r_s[i+1]),
      .x_o   (x_s[i+1]),
      .y_o   (y_s[i+1]),
      .z_o   (z_s[i+1])
    );
  end

  // geometry tail
  logic                g_valid;
  logic [RANGE_BITS:0] g_range;
  logic                g_masked;

  lbfm_geom #(
    .RANGE_BITS(RANGE_BITS),
    .XW        (XW)
  ) u_geom (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .ctrl_i          (c_s[NS]),
    .r_i             (r_s[NS]),
    .x_i             (x_s[NS]),
    .y_i             (y_s[NS]),
    .min_range       (min_range_r),
    .offset_x        (offset_x_r),
    .offset_y        (offset_y_r),
    .footprint_radius(footprint_r),
    .valid_o         (g_valid),
    .range_o         (g_range),
    .masked_o        (g_masked)
  );

  // output register and skid
  logic                out_v_r, out_v_nxt, skid_v_nxt;
  logic [RANGE_BITS:0] out_range_r, out_range_nxt, skid_range_r, skid_range_nxt;
  logic                out_masked_r, out_masked_nxt, skid_masked_r, skid_masked_nxt;
  logic                slot_free;

  assign slot_free = !out_v_r || !out_stall;

  always_comb begin
    out_v_nxt       = out_v_r;
    out_range_nxt   = out_range_r;
    out_masked_nxt  = out_masked_r;
    skid_v_nxt      = skid_v_r;
    skid_range_nxt  = skid_range_r;
    skid_masked_nxt = skid_masked_r;
    if (slot_free) begin
      if (skid_v_r) begin
        out_v_nxt      = 1'b1;
        out_range_nxt  = skid_range_r;
        out_masked_nxt = skid_masked_r;
        skid_v_nxt     = 1'b0;
      end else begin
        out_v_nxt      = g_valid;
        out_range_nxt  = g_range;
        out_masked_nxt = g_masked;
      end
    end else if (en && g_valid) begin
      skid_v_nxt      = 1'b1;
      skid_range_nxt  = g_range;
      skid_masked_nxt = g_masked;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_range_r   <= out_range_nxt;
    out_masked_r  <= out_masked_nxt;
    skid_range_r  <= skid_range_nxt;
    skid_masked_r <= skid_masked_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_range_out = signed'(out_range_r);
  assign out_masked    = out_masked_r;

endmodule

[rtl/lbfm_checker.sv]
// port-level checks for the laser beam footprint mask
module lbfm_checker #(
  parameter int RANGE_BITS = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [RANGE_BITS:0]  out_range_out,
  input logic                        out_masked
);

  localparam logic signed [RANGE_BITS+1:0] LOW_MASKED =
    -(RANGE_BITS + 2)'(lbfm_pkg::MASK_BACKOFF);
  localparam logic signed [RANGE_BITS+1:0] HIGH_MASKED =
    (RANGE_BITS + 2)'((1 << RANGE_BITS) - 1 - lbfm_pkg::MASK_BACKOFF);

  logic signed [RANGE_BITS+1:0] range_ext;
  assign range_ext = (RANGE_BITS + 2)'(out_range_out);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input held off only while a result is waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // masked beams carry a range within the bounds of min range less backoff
  a_masked_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_masked |-> range_ext >= LOW_MASKED && range_ext <= HIGH_MASKED)
    else $error("masked range out of bounds");

  // passed beams are never negative
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_masked |-> !out_range_out[RANGE_BITS])
    else $error("passed range negative");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_range_out) && $stable(out_masked))
    else $error("stalled result changed");

endmodule

bind laser_beam_footprint_mask lbfm_checker #(
  .RANGE_BITS(RANGE_BITS)
) u_lbfm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_range_out(out_range_out),
  .out_masked   (out_masked)
);

[test/tb_top.sv]
// self-checking testbench for the laser beam footprint mask: random and directed beams
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANGE_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int ROT_STEPS = 24;
  localparam longint RECIP_GAIN = 64'sd652032874;
  localparam longint BACKOFF_MM = 10;
  localparam int PHASES = 10;
  localparam int BEAMS_PER_PHASE = 120;
  localparam int BURST_BEAMS = 100;
  localparam int HOLD_CYCLES = 150;
  localparam logic [lbfm_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [lbfm_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint ARCTAN [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85005268, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic [RANGE_BITS-1:0] range_mm;
    logic [ANGLE_BITS-1:0] angle;
    logic                  not_finite;
  } beam_t;

  typedef struct {
    logic [RANGE_BITS:0] range_out;
    logic                masked;
  } masked_beam_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [RANGE_BITS-1:0]     in_range_in = '0;
  logic [ANGLE_BITS-1:0]     in_beam_angle = '0;
  logic                      in_not_finite = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [RANGE_BITS:0] out_range_out;
  logic                      out_masked;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [lbfm_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  // register copies
  logic [RANGE_BITS-1:0]        min_range_mm = '0;
  logic [RANGE_BITS-1:0]        max_range_mm = '1;
  logic signed [RANGE_BITS-1:0] offset_x_mm = '0;
  logic signed [RANGE_BITS-1:0] offset_y_mm = '0;
  logic [ANGLE_BITS-1:0]        mount_ang = '0;
  logic [RANGE_BITS-1:0]        radius_mm = '0;

  beam_t        beam_q[$];
  masked_beam_t masked_beam_q[$];

  logic in_xfer = 1'b0;
  logic out_xfer = 1'b0;
  logic rx_hold = 1'b0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   tx_max = 7;
  int   rx_max = 7;
  int   err_cnt = 0;
  event stall_burst;

  laser_beam_footprint_mask #(
    .RANGE_BITS(RANGE_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_range_in  (in_range_in),
    .in_beam_angle(in_beam_angle),
    .in_not_finite(in_not_finite),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_range_out(out_range_out),
    .out_masked   (out_masked),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial forever #5 clk = ~clk;

  function automatic masked_beam_t footprint_mask(beam_t b);
    masked_beam_t r;
    logic [ANGLE_BITS-1:0] ang_sum;
    logic [31:0] phase;
    longint s, x, y, z, dx, dy, px, py, ox, oy, rq, m;
    longint unsigned d2, r2;
    r.range_out = {1'b0, b.range_mm};
    r.masked = 1'b0;
    if (b.not_finite || b.range_mm > max_range_mm || b.range_mm < min_range_mm) begin
      return r;
    end
    ang_sum = b.angle + mount_ang;
    phase = 32'(ang_sum) << (32 - ANGLE_BITS);
    s = longint'(b.range_mm) << 8;
    case (phase[31:30])
      2'd0: begin x = s; y = 0; end
      2'd1: begin x = 0; y = s; end
      2'd2: begin x = -s; y = 0; end
      default: begin x = 0; y = -s; end
    endcase
    z = longint'(phase[29:0]);
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN[i];
      end
    end
    ox = offset_x_mm;
    oy = offset_y_mm;
    px = ((x * RECIP_GAIN + (longint'(1) << 33)) >>> 34) + ox * 16;
    py = ((y * RECIP_GAIN + (longint'(1) << 33)) >>> 34) + oy * 16;
    d2 = px * px + py * py;
    rq = longint'(radius_mm) << 4;
    r2 = rq * rq;
    if (d2 < r2) begin
      m = longint'(min_range_mm) - BACKOFF_MM;
      r.range_out = m[RANGE_BITS:0];
      r.masked = 1'b1;
    end
    return r;
  endfunction

  // sample both channels
  always @(posedge clk) begin
    beam_t b;
    masked_beam_t want;
    in_xfer = rst_n && in_valid && !in_stall;
    out_xfer = rst_n && out_valid && !out_stall;
    if (in_xfer) begin
      b.range_mm = in_range_in;
      b.angle = in_beam_angle;
      b.not_finite = in_not_finite;
      masked_beam_q.push_back(footprint_mask(b));
    end
    if (out_xfer) begin
      if (masked_beam_q.size() == 0) begin
        if (err_cnt < 10) begin
          $display("%0t: result transfer with no beam pending: range_out %0d masked %0b",
                   $time, out_range_out, out_masked);
        end
        err_cnt++;
      end else begin
        want = masked_beam_q.pop_front();
        if (out_range_out !== want.range_out || out_masked !== want.masked) begin
          if (err_cnt < 10) begin
            $display("%0t: mismatch range_out exp %0d got %0d, masked exp %0b got %0b",
                     $time, $signed(want.range_out), out_range_out, want.masked, out_masked);
          end
          err_cnt++;
        end
      end
    end
  end

  // beam driver
  always @(negedge clk) begin
    logic next_valid;
    beam_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid && !in_xfer;
      if (in_xfer) tx_gap = $urandom_range(0, tx_max);
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (beam_q.size() > 0) begin
          b = beam_q.pop_front();
          in_range_in <= b.range_mm;
          in_beam_angle <= b.angle;
          in_not_finite <= b.not_finite;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_xfer) rx_wait = $urandom_range(0, rx_max);
      if (rx_hold) begin
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold
  initial forever begin
    @(stall_burst);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("** laser_beam_footprint_mask: FAILED **");
    $finish;
  end

  task automatic write_reg(input logic [lbfm_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value[15:0]};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      lbfm_pkg::REG_MIN_RANGE:   min_range_mm = value[15:0];
      lbfm_pkg::REG_MAX_RANGE:   max_range_mm = value[15:0];
      lbfm_pkg::REG_OFFSET_X:    offset_x_mm = value[15:0];
      lbfm_pkg::REG_OFFSET_Y:    offset_y_mm = value[15:0];
      lbfm_pkg::REG_MOUNT_ANGLE: mount_ang = value[15:0];
      lbfm_pkg::REG_FOOTPRINT:   radius_mm = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input int min_r, input int max_r, input int off_x, input int off_y,
                            input int mount, input int radius);
    write_reg(lbfm_pkg::REG_MIN_RANGE, min_r);
    write_reg(lbfm_pkg::REG_MAX_RANGE, max_r);
    write_reg(lbfm_pkg::REG_OFFSET_X, off_x);
    write_reg(lbfm_pkg::REG_OFFSET_Y, off_y);
    write_reg(lbfm_pkg::REG_MOUNT_ANGLE, mount);
    write_reg(lbfm_pkg::REG_FOOTPRINT, radius);
    // unmapped address, must be ignored
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
  endtask

  task automatic wait_results();
    do @(posedge clk); while (beam_q.size() != 0 || in_valid || masked_beam_q.size() != 0);
  endtask

  task automatic add_beam(input int range_mm, input int angle, input bit not_finite);
    beam_t b;
    b.range_mm = range_mm[RANGE_BITS-1:0];
    b.angle = angle[ANGLE_BITS-1:0];
    b.not_finite = not_finite;
    beam_q.push_back(b);
  endtask

  // biased toward ranges near the footprint and the window edges
  function automatic beam_t rand_beam();
    beam_t b;
    int near, ox, oy;
    ox = offset_x_mm;
    oy = offset_y_mm;
    if (ox < 0) ox = -ox;
    if (oy < 0) oy = -oy;
    near = 2 * int'(radius_mm) + ox + oy;
    if (near > 65535) near = 65535;
    b.not_finite = ($urandom_range(0, 7) == 0);
    b.angle = ANGLE_BITS'($urandom);
    case ($urandom_range(0, 3))
      0: b.range_mm = RANGE_BITS'($urandom);
      3: begin
        case ($urandom_range(0, 5))
          0: b.range_mm = '0;
          1: b.range_mm = '1;
          2: b.range_mm = min_range_mm;
          3: b.range_mm = max_range_mm;
          4: b.range_mm = min_range_mm - 1'b1;
          default: b.range_mm = max_range_mm + 1'b1;
        endcase
      end
      default: b.range_mm = RANGE_BITS'($urandom_range(int'(min_range_mm), near));
    endcase
    return b;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero footprint, full window
    add_beam(0, 0, 0);
    add_beam(16'hFFFF, 16'hFFFF, 0);
    add_beam(16'h1234, 16'h8000, 1);
    add_beam(5, 16'h4000, 0);
    wait_results();

    set_config(100, 60000, 200, -150, 16'h4000, 500);
    add_beam(99, 0, 0);
    add_beam(100, 0, 0);
    add_beam(60000, 16'h2000, 0);
    add_beam(60001, 0, 0);
    add_beam(300, 16'h1000, 1);
    add_beam(300, 16'h0000, 0);
    add_beam(300, 16'h4000, 0);
    add_beam(300, 16'h8000, 0);
    add_beam(300, 16'hC000, 0);
    add_beam(250, 16'hFFFF, 0);
    add_beam(400, 16'hE000, 0);
    add_beam(16'hFFFF, 16'hFFFF, 1);
    wait_results();

    // window with min above max
    set_config(5000, 4000, 0, 0, 0, 2000);
    add_beam(4500, 0, 0);
    add_beam(3000, 16'h7000, 0);
    add_beam(6000, 16'hA000, 0);
    wait_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(0, 16'hFFFF, 0, 0, 0, 16'hFFFF);
        1: set_config(16'hFFFF, 16'hFFFF, -32768, 32767, 16'hFFFF, 0);
        2: set_config(0, 16'hFFFF, 32767, -32768, 16'h8000, 16'hFFFF);
        default: set_config($urandom_range(0, 300), $urandom_range(20000, 65535),
                            int'($urandom_range(0, 2000)) - 1000,
                            int'($urandom_range(0, 2000)) - 1000,
                            $urandom_range(0, 65535), $urandom_range(200, 3000));
      endcase
      tx_max = (p % 3 == 2) ? 0 : 7;
      rx_max = (p % 4 == 1) ? 0 : 7;
      if (p == 4) begin
        // fill the pipe against a held output
        tx_max = 0;
        -> stall_burst;
        repeat (BURST_BEAMS) beam_q.push_back(rand_beam());
        wait_results();
        tx_max = 7;
        repeat (BEAMS_PER_PHASE - BURST_BEAMS) beam_q.push_back(rand_beam());
      end else begin
        repeat (BEAMS_PER_PHASE) beam_q.push_back(rand_beam());
      end
      wait_results();
    end

    repeat (40) @(posedge clk);
    if (err_cnt == 0 && masked_beam_q.size() == 0) begin
      $display("** laser_beam_footprint_mask: PASSED **");
    end else begin
      $display("** laser_beam_footprint_mask: FAILED **");
    end
    $finish;
  end

endmodule
